@@ rtl/core/sha512_hash_engine_macros.svh @@
// ----------------------------------------------------------------------------
// sha512 engine assertion macros
// shared concurrent check shorthands, sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SHA512_HASH_ENGINE_MACROS_SVH
`define SHA512_HASH_ENGINE_MACROS_SVH

// same-cycle implication
`define SHA512_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA512_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sha512_pkg.sv @@
// ----------------------------------------------------------------------------
// sha512 package
// shared types, initial hash value, round constants and buffer positions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha512_pkg;

  typedef logic [63:0] word_t;
  typedef word_t [15:0] blk_t;
  typedef word_t [7:0] hash_t;

  // status of the compression unit toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } rnd_stat_t;

  localparam int unsigned ROUNDS = 80;

  // byte positions inside the 128-byte block
  localparam logic [6:0] BLK_LAST_POS = 7'd127;
  localparam logic [6:0] LEN_POS      = 7'd120;
  localparam logic [6:0] PAD_LIMIT    = 7'((1024 - 128) / 8);

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [3:0] MAX_BYTES = 4'd8;

  localparam hash_t HASH_IV = '{
    0: 64'h6a09e667f3bcc908,
    1: 64'hbb67ae8584caa73b,
    2: 64'h3c6ef372fe94f82b,
    3: 64'ha54ff53a5f1d36f1,
    4: 64'h510e527fade682d1,
    5: 64'h9b05688c2b3e6c1f,
    6: 64'h1f83d9abfb41bd6b,
    7: 64'h5be0cd19137e2179
  };

  // round constant table, out-of-range index reads zero
  function automatic word_t k_const(input logic [6:0] idx);
    word_t k;
    unique case (idx)
      7'd0:  k = 64'h428a2f98d728ae22;
      7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;
      7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;
      7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;
      7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;
      7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;
      7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;
      7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;
      7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;
      7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;
      7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;
      7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;
      7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;
      7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;
      7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;
      7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;
      7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;
      7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;
      7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;
      7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;
      7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;
      7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;
      7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;
      7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;
      7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;
      7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;
      7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;
      7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;
      7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;
      7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;
      7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;
      7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;
      7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;
      7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;
      7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;
      7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;
      7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;
      7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;
      7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;
      7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;
      7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/core/sha512_stream_if.sv @@
// ----------------------------------------------------------------------------
// sha512 stream interfaces
// valid/ready channels for message input and digest output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sha512_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_data;
  logic [3:0]  byte_count;
  logic        finish;

  modport source (output valid, output message_data, output byte_count,
                  output finish, input ready);
  modport sink (input valid, input message_data, input byte_count,
                input finish, output ready);
endinterface

interface sha512_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

@@ rtl/core/sha512_round.sv @@
// ----------------------------------------------------------------------------
// sha512 compression unit
// one round per cycle over the 80 rounds, rolling 16-word message schedule
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha512_hash_engine_macros.svh"

module sha512_round (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start_i,
  input  sha512_pkg::blk_t      blk_i,
  input  sha512_pkg::hash_t     hash_i,
  output sha512_pkg::rnd_stat_t stat_o,
  output sha512_pkg::hash_t     vars_o
);

  function automatic sha512_pkg::word_t rotr(input sha512_pkg::word_t x,
                                             input logic [5:0] n);
    return (x >> n) | (x << (7'd64 - {1'b0, n}));
  endfunction

  sha512_pkg::blk_t  win_r;
  sha512_pkg::hash_t vars_r;
  sha512_pkg::word_t kw_r;
  logic [6:0]        cnt_r;
  logic              busy_r;
  logic              done_r;

  sha512_pkg::word_t a, b, c, d, e, f, g, h;
  sha512_pkg::word_t sum1, ch, t1, sum0, maj, t2;
  sha512_pkg::word_t sig0, sig1, w_nxt, kw_nxt;
  logic [6:0]        cnt_inc;

  always_comb begin
    a = vars_r[0]; b = vars_r[1]; c = vars_r[2]; d = vars_r[3];
    e = vars_r[4]; f = vars_r[5]; g = vars_r[6]; h = vars_r[7];
    sum1 = rotr(e, 6'd14) ^ rotr(e, 6'd18) ^ rotr(e, 6'd41);
    ch   = (e & f) ^ (~e & g);
    t1   = h + sum1 + ch + kw_r;
    sum0 = rotr(a, 6'd28) ^ rotr(a, 6'd34) ^ rotr(a, 6'd39);
    maj  = (a & b) ^ (a & c) ^ (b & c);
    t2   = sum0 + maj;
    // schedule word sixteen ahead of the current round
    sig0  = rotr(win_r[1], 6'd1) ^ rotr(win_r[1], 6'd8) ^ (win_r[1] >> 7);
    sig1  = rotr(win_r[14], 6'd19) ^ rotr(win_r[14], 6'd61) ^ (win_r[14] >> 6);
    w_nxt = sig1 + win_r[9] + sig0 + win_r[0];
    cnt_inc = cnt_r + 7'd1;
    kw_nxt  = sha512_pkg::k_const(cnt_inc) + win_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_inc;
        if (cnt_r == 7'(sha512_pkg::ROUNDS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start_i) begin
      win_r  <= blk_i;
      vars_r <= hash_i;
      kw_r   <= sha512_pkg::k_const(7'd0) + blk_i[0];
    end else if (busy_r) begin
      vars_r <= '{0: t1 + t2, 1: a, 2: b, 3: c, 4: d + t1, 5: e, 6: f, 7: g};
      win_r  <= {w_nxt, win_r[15:1]};
      kw_r   <= kw_nxt;
    end
  end

  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;
  assign vars_o      = vars_r;

  `SHA512_ASSERT_NXT(a_start_busy, start_i, busy_r && cnt_r == 7'd0, "start did not launch rounds")
  `SHA512_ASSERT_NXT(a_last_done, busy_r && !start_i && cnt_r == 7'(sha512_pkg::ROUNDS - 1), done_r && !busy_r, "round 79 did not finish")
  `SHA512_ASSERT_IMP(a_done_idle, done_r, !busy_r, "done while rounds still running")

endmodule

@@ rtl/core/sha512_hash_engine.sv @@
// ----------------------------------------------------------------------------
// sha512 hash engine
// appends message bytes to a 128-byte block, compresses full blocks, pads on
// finish and streams the eight digest words
// input: ready only in idle, so an item holds it while its bytes are written and any block they fill is compressed
// finish writes the marker byte, then zero padding and the length field, compressing each padding block
// digest: eight output transfers, one per cycle when the sink is ready
// the compression unit runs one round per cycle and sets the block time
// reset (synchronous, rst_n low): idle, hash at initial value, bit count zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha512_hash_engine_macros.svh"

module sha512_hash_engine (
  input  logic          clk,
  input  logic          rst_n,
  sha512_in_if.sink     in_chan,
  sha512_out_if.source  out_chan
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTES,
    S_CMP_MSG,
    S_FIN_MARK,
    S_PAD,
    S_CMP_PAD,
    S_DIGEST
  } state_t;

  state_t                state_r;
  logic [63:0]           data_r;      // remaining bytes, next one on top
  logic [3:0]            cnt_r;       // bytes left in the current item
  logic                  fin_r;
  logic [63:0]           bit_count_r;
  logic [7:0]            pad_pos_r;   // bit 7 set means block complete
  logic                  len_blk_r;   // length field goes into this block
  logic                  start_r;
  logic [2:0]            out_idx_r;
  sha512_pkg::hash_t     hash_r;
  sha512_pkg::blk_t      blk_r;

  sha512_pkg::rnd_stat_t rstat;
  sha512_pkg::hash_t     vars;

  logic [6:0] cur_pos;
  logic [3:0] in_cnt;
  logic       wr_en;
  logic [6:0] wr_pos;
  logic [7:0] wr_byte;
  logic       in_xfer;
  logic       out_xfer;

  // byte position of the next message byte within the block
  assign cur_pos = bit_count_r[9:3];
  assign in_cnt  = (in_chan.byte_count > sha512_pkg::MAX_BYTES) ? sha512_pkg::MAX_BYTES
                                                              : in_chan.byte_count;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  assign out_chan.valid       = (state_r == S_DIGEST);
  assign out_chan.digest_word = hash_r[out_idx_r];
  assign out_chan.word_index  = out_idx_r;
  assign out_chan.last_word   = (out_idx_r == 3'd7);
  assign out_xfer             = out_chan.valid && out_chan.ready;

  // single byte write port into the block buffer
  always_comb begin
    wr_en   = 1'b0;
    wr_pos  = cur_pos;
    wr_byte = '0;
    unique case (state_r)
      S_BYTES: begin
        wr_en   = 1'b1;
        wr_byte = data_r[63:56];
      end
      S_FIN_MARK: begin
        wr_en   = 1'b1;
        wr_byte = sha512_pkg::PAD_MARK;
      end
      S_PAD: begin
        wr_en  = !pad_pos_r[7];
        wr_pos = pad_pos_r[6:0];
        // length bytes in the tail of the final block, zeros elsewhere
        if (len_blk_r && pad_pos_r[6:0] >= sha512_pkg::LEN_POS) begin
          wr_byte = bit_count_r[{~pad_pos_r[2:0], 3'b000} +: 8];
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // block buffer, every byte is written before a compression reads it
  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk_r[wr_pos[6:3]][{~wr_pos[2:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  sha512_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start_r),
    .blk_i   (blk_r),
    .hash_i  (hash_r),
    .stat_o  (rstat),
    .vars_o  (vars)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fin_r       <= 1'b0;
      bit_count_r <= '0;
      pad_pos_r   <= '0;
      len_blk_r   <= 1'b0;
      start_r     <= 1'b0;
      out_idx_r   <= '0;
      hash_r      <= sha512_pkg::HASH_IV;
    end else begin
      start_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            data_r <= in_chan.message_data;
            cnt_r  <= in_cnt;
            fin_r  <= in_chan.finish;
            priority if (in_cnt != 4'd0) begin
              state_r <= S_BYTES;
            end else if (in_chan.finish) begin
              state_r <= S_FIN_MARK;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_BYTES: begin
          data_r      <= {data_r[55:0], 8'h00};
          cnt_r       <= cnt_r - 4'd1;
          bit_count_r <= bit_count_r + 64'd8;
          priority if (cur_pos == sha512_pkg::BLK_LAST_POS) begin
            // block full: launch compression once the last byte has landed
            start_r <= 1'b1;
            state_r <= S_CMP_MSG;
          end else if (cnt_r == 4'd1) begin
            state_r <= fin_r ? S_FIN_MARK : S_IDLE;
          end else begin
            state_r <= S_BYTES;
          end
        end
        S_CMP_MSG: begin
          if (rstat.done) begin
            for (int i = 0; i < 8; i++) begin
              hash_r[i] <= hash_r[i] + vars[i];
            end
            priority if (cnt_r != 4'd0) begin
              state_r <= S_BYTES;
            end else if (fin_r) begin
              state_r <= S_FIN_MARK;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_FIN_MARK: begin
          pad_pos_r <= {1'b0, cur_pos} + 8'd1;
          // no room for the length field after the marker: spill to a second block
          len_blk_r <= (cur_pos < sha512_pkg::PAD_LIMIT);
          state_r   <= S_PAD;
        end
        S_PAD: begin
          if (pad_pos_r[7]) begin
            start_r <= 1'b1;
            state_r <= S_CMP_PAD;
          end else begin
            pad_pos_r <= pad_pos_r + 8'd1;
          end
        end
        S_CMP_PAD: begin
          if (rstat.done) begin
            for (int i = 0; i < 8; i++) begin
              hash_r[i] <= hash_r[i] + vars[i];
            end
            if (len_blk_r) begin
              out_idx_r <= '0;
              state_r   <= S_DIGEST;
            end else begin
              pad_pos_r <= '0;
              len_blk_r <= 1'b1;
              state_r   <= S_PAD;
            end
          end
        end
        S_DIGEST: begin
          if (out_xfer) begin
            out_idx_r <= out_idx_r + 3'd1;
            if (out_idx_r == 3'd7) begin
              // message done: fresh hash state for the next one
              hash_r      <= sha512_pkg::HASH_IV;
              bit_count_r <= '0;
              state_r     <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `SHA512_ASSERT_IMP(a_in_round_idle, in_xfer, !rstat.busy && !start_r, "input transfer during compression")
  `SHA512_ASSERT_IMP(a_out_round_idle, out_chan.valid, !rstat.busy, "digest shown during compression")
  `SHA512_ASSERT_IMP(a_done_in_wait, rstat.done, state_r == S_CMP_MSG || state_r == S_CMP_PAD, "compression ended outside a wait state")
  `SHA512_ASSERT_NXT(a_last_clears, out_xfer && out_chan.last_word, bit_count_r == 64'd0 && state_r == S_IDLE, "engine not reinitialized after digest")

endmodule
